// ----- hdl/pid_integral_separation_clamp_unit_assert.svh -----
// Assertion macros shared by the PID integral separation clamp unit.
`ifndef PID_INTEGRAL_SEPARATION_CLAMP_UNIT_ASSERT_SVH
`define PID_INTEGRAL_SEPARATION_CLAMP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PISC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PISC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/pisc_pkg.sv -----
// Package with widths, register indexes and stage types of the PID clamp unit.
package pisc_pkg;

   // Field and datapath widths.
   localparam int GAIN_W   = 16;
   localparam int ANGLE_W  = 16;
   localparam int BAND_W   = 16;
   localparam int ERR_W    = ANGLE_W + 1;
   localparam int SUM_W    = ERR_W + 1;
   localparam int DIFF_W   = ERR_W + 1;
   localparam int PROD_P_W = GAIN_W + ERR_W;
   localparam int PROD_I_W = GAIN_W + SUM_W;
   localparam int PROD_D_W = GAIN_W + DIFF_W;
   localparam int ACC_W    = PROD_D_W + 2;
   localparam int DRIVE_W  = 32;
   localparam int CSR_IDX_W = 3;

   // Default fraction width of the gains.
   localparam int FRAC_BITS_DEFAULT = 8;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEPARATION_BAND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_LIMIT  = 3'd4;

   // Register reset values.
   localparam logic [GAIN_W-1:0] GAIN_P_RESET          = 16'd1152;
   localparam logic [GAIN_W-1:0] GAIN_I_RESET          = 16'd118;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET          = 16'd3072;
   localparam logic [BAND_W-1:0] SEPARATION_BAND_RESET = 16'd6;
   localparam logic [BAND_W-1:0] INTEGRAL_LIMIT_RESET  = 16'd1000;

   // Terms handed from the integrator stage to the multiplier stage.
   typedef struct packed {
      logic signed [ERR_W-1:0]  err;
      logic signed [SUM_W-1:0]  integral;
      logic signed [DIFF_W-1:0] diff;
   } terms_type;

endpackage

// ----- hdl/pisc_integrator.sv -----
// Error, integral separation, integral clamp and error change stage.
`include "pid_integral_separation_clamp_unit_assert.svh"

module pisc_integrator
   import pisc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [ANGLE_W-1:0] in_measured,
   input  logic signed [ANGLE_W-1:0] in_setpoint,
   input  logic [BAND_W-1:0]         separation_band,
   input  logic [BAND_W-1:0]         integral_limit,
   output logic                      out_valid,
   input  logic                      out_ready,
   output terms_type                 out_terms
);

   logic                      valid_ff;
   logic                      valid_in;
   logic                      load;
   logic signed [ERR_W-1:0]   prev_err_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   terms_type                 terms_ff;
   terms_type                 terms_in;
   logic signed [ERR_W-1:0]   err;
   logic [ERR_W-1:0]          mag;
   logic                      in_band;
   logic signed [SUM_W:0]     raw_sum;
   logic signed [SUM_W:0]     lim_pos;
   logic signed [SUM_W:0]     lim_neg;
   logic signed [SUM_W:0]     clamped;

   // Stage handshake: load when the stage is empty or its item leaves.
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   // Error, its magnitude and the separation test.
   assign err     = ERR_W'(in_setpoint) - ERR_W'(in_measured);
   assign mag     = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
   assign in_band = mag < {1'b0, separation_band};

   // Integrate inside the band, clear outside, then clamp to the limit.
   assign raw_sum = in_band ? ((SUM_W+1)'(sum_ff) + (SUM_W+1)'(err)) : '0;
   assign lim_pos = $signed({{(SUM_W+1-BAND_W){1'b0}}, integral_limit});
   assign lim_neg = -lim_pos;

   always_comb begin
      if (raw_sum > lim_pos) begin
         clamped = lim_pos;
      end else if (raw_sum < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = raw_sum;
      end
   end

   assign sum_in            = clamped[SUM_W-1:0];
   assign terms_in.err      = err;
   assign terms_in.integral = sum_in;
   assign terms_in.diff     = DIFF_W'(err) - DIFF_W'(prev_err_ff);

   // Controller state and stage valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         prev_err_ff <= '0;
         sum_ff      <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            prev_err_ff <= err;
            sum_ff      <= sum_in;
         end
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (load) begin
         terms_ff <= terms_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_terms = terms_ff;

   `PISC_ASSERT_NEXT(a_integral_in_limit, clock, reset, load, (sum_ff <= $signed({{(SUM_W-BAND_W){1'b0}}, $past(integral_limit)})) && (sum_ff >= -$signed({{(SUM_W-BAND_W){1'b0}}, $past(integral_limit)})), "integral outside clamp limit")
   `PISC_ASSERT_NEXT(a_cleared_outside_band, clock, reset, load && !in_band, sum_ff == '0, "integral not cleared outside band")
   `PISC_ASSERT_NEXT(a_prev_tracks_err, clock, reset, load, out_terms.err == prev_err_ff, "previous error not updated with the stage")

endmodule

// ----- hdl/pisc_products.sv -----
// Gain multiplier stage followed by the three-term adder stage.
module pisc_products
   import pisc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [GAIN_W-1:0] gain_p,
   input  logic signed [GAIN_W-1:0] gain_i,
   input  logic signed [GAIN_W-1:0] gain_d,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  terms_type                in_terms,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [ACC_W-1:0]  out_acc
);

   logic                       prod_valid_ff;
   logic                       prod_valid_in;
   logic                       prod_ready;
   logic                       prod_load;
   logic signed [PROD_P_W-1:0] prod_p_ff;
   logic signed [PROD_I_W-1:0] prod_i_ff;
   logic signed [PROD_D_W-1:0] prod_d_ff;
   logic signed [PROD_P_W-1:0] prod_p_in;
   logic signed [PROD_I_W-1:0] prod_i_in;
   logic signed [PROD_D_W-1:0] prod_d_in;
   logic                       acc_valid_ff;
   logic                       acc_valid_in;
   logic                       acc_ready;
   logic                       acc_load;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;

   // Handshake of the two stages.
   assign acc_ready     = !acc_valid_ff || out_ready;
   assign acc_load      = prod_valid_ff && acc_ready;
   assign prod_ready    = !prod_valid_ff || acc_ready;
   assign prod_load     = in_valid && prod_ready;
   assign in_ready      = prod_ready;
   assign prod_valid_in = prod_load ? 1'b1 : (acc_ready ? 1'b0 : prod_valid_ff);
   assign acc_valid_in  = acc_load ? 1'b1 : (out_ready ? 1'b0 : acc_valid_ff);

   // Three independent signed products.
   assign prod_p_in = PROD_P_W'(gain_p) * PROD_P_W'(in_terms.err);
   assign prod_i_in = PROD_I_W'(gain_i) * PROD_I_W'(in_terms.integral);
   assign prod_d_in = PROD_D_W'(gain_d) * PROD_D_W'(in_terms.diff);

   // Exact sum of the products.
   assign acc_in = ACC_W'(prod_p_ff) + ACC_W'(prod_i_ff) + ACC_W'(prod_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         acc_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         acc_valid_ff  <= acc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_load) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
      if (acc_load) begin
         acc_ff <= acc_in;
      end
   end

   assign out_valid = acc_valid_ff;
   assign out_acc   = acc_ff;

endmodule

// ----- hdl/pisc_output.sv -----
// Truncation toward zero, saturation and the result register.
`include "pid_integral_separation_clamp_unit_assert.svh"

module pisc_output
   import pisc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [ACC_W-1:0] in_acc,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [DRIVE_W-1:0]      out_drive
);

   localparam logic signed [ACC_W-1:0] DRIVE_MAX =
      {{(ACC_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] DRIVE_MIN =
      {{(ACC_W-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

   logic                    valid_ff;
   logic                    valid_in;
   logic                    load;
   logic [DRIVE_W-1:0]      drive_ff;
   logic [DRIVE_W-1:0]      drive_in;
   logic signed [ACC_W-1:0] bias;
   logic signed [ACC_W-1:0] biased;
   logic signed [ACC_W-1:0] quotient;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   // A negative sum gets 2^FRAC_BITS - 1 added so the shift rounds toward zero.
   assign bias     = in_acc[ACC_W-1] ? {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}} : '0;
   assign biased   = in_acc + bias;
   assign quotient = biased >>> FRAC_BITS;

   // Saturate to the signed 32-bit range.
   always_comb begin
      if (quotient > DRIVE_MAX) begin
         drive_in = DRIVE_MAX[DRIVE_W-1:0];
      end else if (quotient < DRIVE_MIN) begin
         drive_in = DRIVE_MIN[DRIVE_W-1:0];
      end else begin
         drive_in = quotient[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff <= drive_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_drive = drive_ff;

   `PISC_ASSERT_NEXT(a_sign_kept_pos, clock, reset, load && !in_acc[ACC_W-1], !out_drive[DRIVE_W-1], "nonnegative sum gave negative drive")
   `PISC_ASSERT_NEXT(a_sign_kept_neg, clock, reset, load && in_acc[ACC_W-1], out_drive[DRIVE_W-1] || (out_drive == '0), "negative sum gave positive drive")

endmodule

// ----- hdl/pid_integral_separation_clamp_unit.sv -----
// Top level of the positional PID controller with integral separation and clamp.
// One control tick per transfer: req_tdata carries the measured and target angle, and
// rsp_tdata returns the drive value, (Kp*e + Ki*integral + Kd*(e - e_prev)) / 2^FRAC_BITS
// truncated toward zero and saturated to 32 bits. The integral grows by the error only
// while |e| is strictly below separation_band, is cleared otherwise, and is clamped to
// +/- integral_limit. A new tick is accepted every cycle unless the result side stalls;
// each tick passes the input, error/integral, multiplier, adder and output registers. The
// user must write gains and limits through the csr_ port only while idle; no check is made.
module pid_integral_separation_clamp_unit
   import pisc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   // Input transfer channel.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // [15:0] measured, [31:16] setpoint
   // Result transfer channel.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DRIVE_W-1:0]   rsp_tdata,   // [31:0] drive
   // Configuration write port.
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata
);

   logic [GAIN_W-1:0]          gain_p_ff;
   logic [GAIN_W-1:0]          gain_i_ff;
   logic [GAIN_W-1:0]          gain_d_ff;
   logic [BAND_W-1:0]          band_ff;
   logic [BAND_W-1:0]          limit_ff;
   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic                       in_load;
   logic signed [ANGLE_W-1:0]  measured_ff;
   logic signed [ANGLE_W-1:0]  setpoint_ff;
   logic                       integ_ready;
   logic                       terms_valid;
   logic                       terms_ready;
   terms_type                  terms;
   logic                       acc_valid;
   logic                       acc_ready;
   logic signed [ACC_W-1:0]    acc;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= GAIN_P_RESET;
         gain_i_ff <= GAIN_I_RESET;
         gain_d_ff <= GAIN_D_RESET;
         band_ff   <= SEPARATION_BAND_RESET;
         limit_ff  <= INTEGRAL_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_P:          gain_p_ff <= csr_wdata;
            CSR_GAIN_I:          gain_i_ff <= csr_wdata;
            CSR_GAIN_D:          gain_d_ff <= csr_wdata;
            CSR_SEPARATION_BAND: band_ff   <= csr_wdata;
            CSR_INTEGRAL_LIMIT:  limit_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input register.
   assign req_tready  = !in_valid_ff || integ_ready;
   assign in_load     = req_tvalid && req_tready;
   assign in_valid_in = in_load ? 1'b1 : (integ_ready ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         measured_ff <= req_tdata[ANGLE_W-1:0];
         setpoint_ff <= req_tdata[2*ANGLE_W-1:ANGLE_W];
      end
   end

   // Error and integral stage.
   pisc_integrator u_integrator (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (in_valid_ff),
      .in_ready        (integ_ready),
      .in_measured     (measured_ff),
      .in_setpoint     (setpoint_ff),
      .separation_band (band_ff),
      .integral_limit  (limit_ff),
      .out_valid       (terms_valid),
      .out_ready       (terms_ready),
      .out_terms       (terms)
   );

   // Gain products and their sum.
   pisc_products u_products (
      .clock     (clock),
      .reset     (reset),
      .gain_p    (gain_p_ff),
      .gain_i    (gain_i_ff),
      .gain_d    (gain_d_ff),
      .in_valid  (terms_valid),
      .in_ready  (terms_ready),
      .in_terms  (terms),
      .out_valid (acc_valid),
      .out_ready (acc_ready),
      .out_acc   (acc)
   );

   // Scaling, saturation and result register.
   pisc_output #(
      .FRAC_BITS (FRAC_BITS)
   ) u_output (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_valid),
      .in_ready  (acc_ready),
      .in_acc    (acc),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_drive (rsp_tdata)
   );

endmodule

// ----- test/pid_integral_separation_clamp_unit_tb.sv -----
// Self-checking testbench for the PID integral separation clamp unit.
`timescale 1ns / 100ps

module pid_integral_separation_clamp_unit_tb;
   import pisc_pkg::*;

   localparam int ANGLE_MAX    = 32767;
   localparam int ANGLE_MIN    = -32768;
   localparam int GAP_MAX      = 18;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_TICKS  = 180;
   localparam int PHASES       = 8;
   localparam int CYCLE_LIMIT  = 400000;

   // Highest index the write port can address; indexes above the last register are unused.
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_TOP = '1;

   // Predicts the drive of every accepted tick and checks the returned drives in order.
   class drive_scoreboard;
      int     gain_p;
      int     gain_i;
      int     gain_d;
      int     band;
      int     limit;
      longint prev_err;
      longint err_sum;
      logic [DRIVE_W-1:0] expected_drive[$];
      int     errors;

      function new();
         gain_p   = int'($signed(GAIN_P_RESET));
         gain_i   = int'($signed(GAIN_I_RESET));
         gain_d   = int'($signed(GAIN_D_RESET));
         band     = int'(SEPARATION_BAND_RESET);
         limit    = int'(INTEGRAL_LIMIT_RESET);
         prev_err = 0;
         err_sum  = 0;
         errors   = 0;
      endfunction

      // Mirrors a register write; an unused index leaves everything unchanged.
      function void apply_reg(logic [CSR_IDX_W-1:0] index, logic [GAIN_W-1:0] value);
         case (index)
            CSR_GAIN_P:          gain_p = int'($signed(value));
            CSR_GAIN_I:          gain_i = int'($signed(value));
            CSR_GAIN_D:          gain_d = int'($signed(value));
            CSR_SEPARATION_BAND: band   = int'(value);
            CSR_INTEGRAL_LIMIT:  limit  = int'(value);
            default: ;
         endcase
      endfunction

      // Advances the controller state by one tick and queues the drive it yields.
      function void note_tick(logic [31:0] data);
         logic signed [ANGLE_W-1:0] meas;
         logic signed [ANGLE_W-1:0] setp;
         longint err;
         longint mag;
         longint acc;
         longint quot;
         meas = $signed(data[ANGLE_W-1:0]);
         setp = $signed(data[2*ANGLE_W-1:ANGLE_W]);
         err  = longint'(setp) - longint'(meas);
         mag  = (err < 0) ? -err : err;

         // Integrate only inside the band, then clamp symmetrically.
         if (mag < longint'(band)) begin
            err_sum = err_sum + err;
         end else begin
            err_sum = 0;
         end
         if (err_sum > longint'(limit)) begin
            err_sum = limit;
         end
         if (err_sum < -longint'(limit)) begin
            err_sum = -longint'(limit);
         end

         acc  = gain_p * err + gain_i * err_sum + gain_d * (err - prev_err);
         quot = acc / (longint'(1) <<< FRAC_BITS_DEFAULT);
         if (quot > 64'sd2147483647) begin
            quot = 64'sd2147483647;
         end
         if (quot < -64'sd2147483648) begin
            quot = -64'sd2147483648;
         end
         prev_err = err;
         expected_drive.push_back(quot[DRIVE_W-1:0]);
      endfunction

      // Compares a returned drive with the oldest prediction.
      function void check_drive(logic [DRIVE_W-1:0] got);
         logic [DRIVE_W-1:0] want;
         if (expected_drive.size() == 0) begin
            errors++;
            $display("%0t: unexpected drive, expected none, actual %0d", $time, $signed(got));
         end else begin
            want = expected_drive.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: drive mismatch, expected %0d, actual %0d",
                        $time, $signed(want), $signed(got));
            end
         end
      endfunction

      function int pending();
         return expected_drive.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DRIVE_W-1:0]   rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [GAIN_W-1:0]    csr_wdata = '0;

   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   int cycle_count = 0;

   drive_scoreboard drive_sb = new();

   pid_integral_separation_clamp_unit #(
      .FRAC_BITS(FRAC_BITS_DEFAULT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),    // [15:0] measured, [31:16] setpoint
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),    // [31:0] drive
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock with a 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard stop in case the block hangs or loses a result.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Every transfer on either channel is seen here, sampled at the clock edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            drive_sb.check_drive(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            drive_sb.note_tick(req_tdata);
         end
      end
   end

   // The result side stalls for a random gap before each transfer, with no gap in bursts.
   initial begin
      int stall;
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [ANGLE_W-1:0] clamp_angle(int value);
      if (value > ANGLE_MAX) begin
         return ANGLE_MAX[ANGLE_W-1:0];
      end
      if (value < ANGLE_MIN) begin
         return ANGLE_MIN[ANGLE_W-1:0];
      end
      return value[ANGLE_W-1:0];
   endfunction

   // Offers one tick after a random gap (none in bursts) and returns at the edge of its transfer.
   task automatic send_tick(input logic [ANGLE_W-1:0] meas, input logic [ANGLE_W-1:0] setp);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {setp, meas};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic stop_ticks();
      req_tvalid <= 1'b0;
   endtask

   // Waits until every predicted drive has come back and the pipeline has emptied.
   task automatic wait_idle();
      @(posedge clock);
      while (drive_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [GAIN_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      drive_sb.apply_reg(index, value);
   endtask

   // Writes all registers back to back, plus one write to an unused index.
   task automatic set_regs(input int gp, input int gi, input int gd, input int band,
                           input int limit);
      logic [CSR_IDX_W-1:0] spare;
      spare = CSR_IDX_W'($urandom_range(int'(CSR_INTEGRAL_LIMIT) + 1, int'(CSR_INDEX_TOP)));
      write_reg(spare, GAIN_W'($urandom));
      write_reg(CSR_GAIN_P, gp[GAIN_W-1:0]);
      write_reg(CSR_GAIN_I, gi[GAIN_W-1:0]);
      write_reg(CSR_GAIN_D, gd[GAIN_W-1:0]);
      write_reg(CSR_SEPARATION_BAND, band[BAND_W-1:0]);
      write_reg(CSR_INTEGRAL_LIMIT, limit[BAND_W-1:0]);
      csr_we <= 1'b0;
   endtask

   function automatic int pick_gain();
      logic [GAIN_W-1:0] bits;
      bits = GAIN_W'($urandom);
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return int'($signed(bits));
      endcase
   endfunction

   function automatic int pick_band();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 65535;
         2: return $urandom_range(1, 16);
         3: return $urandom_range(1, 512);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic int pick_limit();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 65535;
         2: return $urandom_range(1, 64);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // Mostly errors inside the band so the integral builds up and hits its clamp.
   task automatic run_random_ticks(input int count);
      logic [ANGLE_W-1:0] rnd;
      int meas;
      int setp;
      int span;
      int band;
      for (int n = 0; n < count; n++) begin
         rnd  = ANGLE_W'($urandom);
         meas = int'($signed(rnd));
         band = drive_sb.band;
         span = (band == 0) ? 0 : band - 1;
         case ($urandom_range(0, 9)) inside
            [0:5]: setp = meas + int'($urandom_range(0, 2 * span)) - span;
            6: setp = $urandom_range(0, 1) ? meas + band : meas - band;
            7: begin
               rnd  = ANGLE_W'($urandom);
               setp = int'($signed(rnd));
            end
            8: begin
               meas = $urandom_range(0, 1) ? ANGLE_MAX : ANGLE_MIN;
               setp = $urandom_range(0, 1) ? ANGLE_MAX : ANGLE_MIN;
            end
            default: setp = meas;
         endcase
         send_tick(meas[ANGLE_W-1:0], clamp_angle(setp));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Default gains: zero error, full-scale errors both ways, error at and inside the band.
      send_tick(16'h0000, 16'h0000);
      send_tick(16'h8000, 16'h7FFF);
      send_tick(16'h7FFF, 16'h8000);
      send_tick(16'h0000, 16'h0006);
      send_tick(16'h0000, 16'hFFFA);
      send_tick(16'h0000, 16'h0005);
      send_tick(16'h0000, 16'h0005);
      send_tick(16'h000A, 16'h0005);
      send_tick(16'h0000, 16'hFFFB);
      stop_ticks();
      wait_idle();

      // Widest band and limit with extreme gains: the integral saturates at its clamp.
      set_regs(32767, 32767, -32768, 65535, 65535);
      send_tick(16'h8001, 16'h7FFF);
      send_tick(16'h8001, 16'h7FFF);
      send_tick(16'h8001, 16'h7FFF);
      send_tick(16'h7FFF, 16'h8001);
      send_tick(16'h7FFF, 16'h8001);
      send_tick(16'h0000, 16'h0000);
      stop_ticks();
      wait_idle();

      // Zero band and zero limit: the integral stays cleared.
      set_regs(-32768, -32768, -32768, 0, 0);
      send_tick(16'h0000, 16'h0000);
      send_tick(16'h0000, 16'h0001);
      send_tick(16'h8000, 16'h7FFF);
      send_tick(16'h0003, 16'h0000);
      stop_ticks();
      wait_idle();

      // Random phases, each under its own register setting and idling pattern.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            set_regs(32767, 32767, 32767, 65535, 65535);
         end else if (phase == 1) begin
            set_regs(-32768, -32768, -32768, 0, 0);
         end else begin
            set_regs(pick_gain(), pick_gain(), pick_gain(), pick_band(), pick_limit());
         end
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         run_random_ticks(PHASE_TICKS);
         stop_ticks();
         wait_idle();
      end

      if (drive_sb.errors == 0 && drive_sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/pisc_pkg.sv
hdl/pisc_integrator.sv
hdl/pisc_products.sv
hdl/pisc_output.sv
hdl/pid_integral_separation_clamp_unit.sv
test/pid_integral_separation_clamp_unit_tb.sv
